// File: rtl/core/svs_pkg.sv
// Shared types and codes for the searchable value stack.
package svs_pkg;

	// Request operation codes
	typedef enum logic [2:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_SEARCH = 3'd2,
		OP_REMOVE = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_COUNT  = 3'd5
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	// Control states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_SCAN,
		ST_SHIFT
	} state_t;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W  = 5;

endpackage

// File: rtl/core/svs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module svs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/searchable_value_stack.sv
// Top level of the searchable value stack: control FSM around one entry RAM.
//
// A bounded LIFO of signed 32-bit values held in a RAM of DEPTH entries. A request
// (op, value) is taken when start is high and busy is low; exactly one result follows,
// shown for one cycle while done is high, and cannot be held off by the receiver.
// Push, clear, unused op codes, and pop/search/remove/count on an empty stack return
// their result in the cycle after the transfer, and busy stays low so a new request
// may follow at once. Pop reads the top entry from the RAM in ST_POP. Search and count
// walk the stored entries from the top through the single RAM read port, one entry per
// cycle, search stopping at the first match. Remove scans down to the topmost match,
// then moves each entry above it down by one, one per cycle. The RAM needs no clearing
// after reset; only the state, the fill level and done reset.
module searchable_value_stack #(
	parameter int unsigned DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [1:0]         status,
	output logic               found,
	output logic signed [31:0] popped_value,
	output logic [4:0]         even_count,
	output logic [4:0]         odd_count,
	output logic [4:0]         fill_level
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned FW = $clog2(DEPTH + 1);
	localparam int unsigned CW = (FW > svs_pkg::CNT_W) ? FW : svs_pkg::CNT_W;

	svs_pkg::state_t state_q, state_nx;

	logic [FW-1:0]               fill_q;
	logic [FW-1:0]               fill_m1;
	logic [AW-1:0]               top_idx;
	logic                        full, empty, accept;
	svs_pkg::op_t                op_in, op_q;
	logic [svs_pkg::DATA_W-1:0]  val_q;
	logic [AW-1:0]               scan_idx_q, mv_idx_q;
	logic [FW-1:0]               cnt_even_q, cnt_odd_q;
	logic                        done_q, found_q;
	svs_pkg::status_t            status_q;
	logic [svs_pkg::DATA_W-1:0]  popped_q;

	// RAM port signals
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr, ram_raddr;
	logic [svs_pkg::DATA_W-1:0]  ram_wdata, ram_rdata;

	// control strobes from the output decoder
	logic                        res_vld, res_found, pop_ld, cnt_en, clr_acc;
	svs_pkg::status_t            res_status;
	logic                        fill_inc, fill_dec, fill_clr;
	logic                        scan_ld, scan_dec, mv_ld, mv_inc;
	logic                        match;

	assign op_in   = svs_pkg::op_t'(op);
	assign busy    = (state_q != svs_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign full    = (fill_q == FW'(DEPTH));
	assign empty   = (fill_q == '0);
	assign fill_m1 = fill_q - FW'(1);
	assign top_idx = fill_m1[AW-1:0];
	assign match   = (ram_rdata == val_q);

	svs_ram #(
		.WIDTH (svs_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			svs_pkg::ST_IDLE: begin
				if (accept && !empty) begin
					case (op_in)
						svs_pkg::OP_POP: state_nx = svs_pkg::ST_POP;
						svs_pkg::OP_SEARCH,
						svs_pkg::OP_REMOVE,
						svs_pkg::OP_COUNT: state_nx = svs_pkg::ST_SCAN;
						default: state_nx = svs_pkg::ST_IDLE;
					endcase
				end
			end
			svs_pkg::ST_POP: state_nx = svs_pkg::ST_IDLE;
			svs_pkg::ST_SCAN: begin
				if (op_q == svs_pkg::OP_COUNT) begin
					if (scan_idx_q == '0) state_nx = svs_pkg::ST_IDLE;
				end else if (match) begin
					if (op_q == svs_pkg::OP_REMOVE && scan_idx_q != top_idx) begin
						state_nx = svs_pkg::ST_SHIFT;
					end else begin
						state_nx = svs_pkg::ST_IDLE;
					end
				end else if (scan_idx_q == '0) begin
					state_nx = svs_pkg::ST_IDLE;
				end
			end
			svs_pkg::ST_SHIFT: begin
				if (mv_idx_q == top_idx) state_nx = svs_pkg::ST_IDLE;
			end
			default: state_nx = svs_pkg::ST_IDLE;
		endcase
	end

	// datapath control and RAM access
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = fill_q[AW-1:0];
		ram_wdata  = value;
		ram_raddr  = top_idx;
		res_vld    = 1'b0;
		res_status = svs_pkg::STAT_OK;
		res_found  = 1'b0;
		pop_ld     = 1'b0;
		cnt_en     = 1'b0;
		clr_acc    = 1'b0;
		fill_inc   = 1'b0;
		fill_dec   = 1'b0;
		fill_clr   = 1'b0;
		scan_ld    = 1'b0;
		scan_dec   = 1'b0;
		mv_ld      = 1'b0;
		mv_inc     = 1'b0;
		case (state_q)
			svs_pkg::ST_IDLE: begin
				if (accept) begin
					clr_acc = 1'b1;
					case (op_in)
						svs_pkg::OP_PUSH: begin
							res_vld = 1'b1;
							if (full) begin
								res_status = svs_pkg::STAT_FULL;
							end else begin
								ram_we   = 1'b1;
								fill_inc = 1'b1;
							end
						end
						svs_pkg::OP_POP: begin
							// read the top entry; result once data returns
							if (empty) begin
								res_vld    = 1'b1;
								res_status = svs_pkg::STAT_EMPTY;
							end else begin
								fill_dec = 1'b1;
							end
						end
						svs_pkg::OP_SEARCH,
						svs_pkg::OP_REMOVE: begin
							if (empty) begin
								res_vld    = 1'b1;
								res_status = svs_pkg::STAT_NOT_FOUND;
							end else begin
								scan_ld = 1'b1;
							end
						end
						svs_pkg::OP_COUNT: begin
							if (empty) res_vld = 1'b1;
							else scan_ld = 1'b1;
						end
						svs_pkg::OP_CLEAR: begin
							res_vld  = 1'b1;
							fill_clr = 1'b1;
						end
						default: res_vld = 1'b1;
					endcase
				end
			end
			svs_pkg::ST_POP: begin
				res_vld = 1'b1;
				pop_ld  = 1'b1;
			end
			svs_pkg::ST_SCAN: begin
				ram_raddr = scan_idx_q - AW'(1);
				if (op_q == svs_pkg::OP_COUNT) begin
					cnt_en   = 1'b1;
					scan_dec = 1'b1;
					res_vld  = (scan_idx_q == '0);
				end else if (match) begin
					res_found = 1'b1;
					if (op_q == svs_pkg::OP_REMOVE) begin
						// topmost match: shift the entries above it down
						ram_raddr = scan_idx_q + AW'(1);
						if (scan_idx_q == top_idx) begin
							res_vld  = 1'b1;
							fill_dec = 1'b1;
						end else begin
							mv_ld = 1'b1;
						end
					end else begin
						res_vld = 1'b1;
					end
				end else begin
					scan_dec = 1'b1;
					if (scan_idx_q == '0) begin
						res_vld    = 1'b1;
						res_status = svs_pkg::STAT_NOT_FOUND;
					end
				end
			end
			svs_pkg::ST_SHIFT: begin
				// move entry mv_idx down one slot, fetch the next one up
				ram_we    = 1'b1;
				ram_waddr = mv_idx_q - AW'(1);
				ram_wdata = ram_rdata;
				ram_raddr = mv_idx_q + AW'(1);
				mv_inc    = 1'b1;
				if (mv_idx_q == top_idx) begin
					res_vld   = 1'b1;
					res_found = 1'b1;
					fill_dec  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svs_pkg::ST_IDLE;
			fill_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= res_vld;
			if (fill_clr) begin
				fill_q <= '0;
			end else if (fill_inc) begin
				fill_q <= fill_q + FW'(1);
			end else if (fill_dec) begin
				fill_q <= fill_m1;
			end
		end
	end

	// request, walk and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_in;
			val_q <= value;
		end
		if (scan_ld) begin
			scan_idx_q <= top_idx;
		end else if (scan_dec) begin
			scan_idx_q <= scan_idx_q - AW'(1);
		end
		if (mv_ld) begin
			mv_idx_q <= scan_idx_q + AW'(1);
		end else if (mv_inc) begin
			mv_idx_q <= mv_idx_q + AW'(1);
		end
		if (clr_acc) begin
			cnt_even_q <= '0;
			cnt_odd_q  <= '0;
			popped_q   <= '0;
		end else begin
			if (cnt_en) begin
				if (ram_rdata[0]) cnt_odd_q <= cnt_odd_q + FW'(1);
				else cnt_even_q <= cnt_even_q + FW'(1);
			end
			if (pop_ld) popped_q <= ram_rdata;
		end
		if (res_vld) begin
			status_q <= res_status;
			found_q  <= res_found;
		end
	end

	// result ports; counts report their low five bits
	logic [CW-1:0] fill_w, even_w, odd_w;

	assign fill_w       = CW'(fill_q);
	assign even_w       = CW'(cnt_even_q);
	assign odd_w        = CW'(cnt_odd_q);
	assign done         = done_q;
	assign status       = status_q;
	assign found        = found_q;
	assign popped_value = popped_q;
	assign even_count   = even_w[svs_pkg::CNT_W-1:0];
	assign odd_count    = odd_w[svs_pkg::CNT_W-1:0];
	assign fill_level   = fill_w[svs_pkg::CNT_W-1:0];

endmodule

// File: tb/tb.sv
// Self-checking testbench for the searchable value stack (directed and random traffic).
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import svs_pkg::*;

	localparam int unsigned STACK_DEPTH = 16;
	localparam int unsigned CYCLE_LIMIT = 400_000;
	localparam int unsigned TAIL_CYCLES = 2 * STACK_DEPTH + 8;
	localparam int unsigned RANDOM_PHASES = 6;
	localparam int unsigned PHASE_ITEMS = 200;

	// Op codes the block accepts but ignores
	localparam logic [2:0] OP_UNUSED_6 = 3'd6;
	localparam logic [2:0] OP_UNUSED_7 = 3'd7;

	// One predicted result
	typedef struct {
		status_t            status;
		logic               found;
		logic signed [31:0] popped;
		logic [4:0]         evens;
		logic [4:0]         odds;
		logic [4:0]         level;
	} stack_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [2:0]         op = 3'd0;
	logic signed [31:0] value = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic               found;
	logic signed [31:0] popped_value;
	logic [4:0]         even_count;
	logic [4:0]         odd_count;
	logic [4:0]         fill_level;

	// Shadow copy of the stack contents
	logic [31:0]        shadow_vals [STACK_DEPTH];
	int unsigned        shadow_fill = 0;

	stack_result_t      pending_results [$];
	int unsigned        fail_count = 0;
	int unsigned        cycle_count = 0;
	int unsigned        burst_left = 0;
	logic [31:0]        value_pool [8];

	searchable_value_stack #(
		.DEPTH(STACK_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.value(value),
		.done(done),
		.status(status),
		.found(found),
		.popped_value(popped_value),
		.even_count(even_count),
		.odd_count(odd_count),
		.fill_level(fill_level)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Apply one operation to the shadow stack and return the result it should give
	function automatic stack_result_t stack_apply(logic [2:0] code, logic [31:0] v);
		stack_result_t r;
		int            hit;
		r.status = STAT_OK;
		r.found  = 1'b0;
		r.popped = '0;
		r.evens  = '0;
		r.odds   = '0;
		hit      = -1;
		// topmost match for search and remove
		for (int i = 0; i < int'(shadow_fill); i++) begin
			if (shadow_vals[i] == v)
				hit = i;
		end
		case (code)
			OP_PUSH: begin
				if (shadow_fill >= STACK_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					shadow_vals[shadow_fill] = v;
					shadow_fill++;
				end
			end
			OP_POP: begin
				if (shadow_fill == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					shadow_fill--;
					r.popped = shadow_vals[shadow_fill];
				end
			end
			OP_SEARCH: begin
				if (hit >= 0)
					r.found = 1'b1;
				else
					r.status = STAT_NOT_FOUND;
			end
			OP_REMOVE: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					for (int i = hit; i + 1 < int'(shadow_fill); i++)
						shadow_vals[i] = shadow_vals[i + 1];
					shadow_fill--;
				end else begin
					r.status = STAT_NOT_FOUND;
				end
			end
			OP_CLEAR: begin
				shadow_fill = 0;
			end
			OP_COUNT: begin
				for (int i = 0; i < int'(shadow_fill); i++) begin
					if (shadow_vals[i][0])
						r.odds++;
					else
						r.evens++;
				end
			end
			default: begin
			end
		endcase
		r.level = shadow_fill[4:0];
		return r;
	endfunction

	// Send one request, record its prediction, then pace the sender in bursts
	task automatic issue(input logic [2:0] code, input logic [31:0] v);
		int unsigned gap;
		start <= 1'b1;
		op    <= code;
		value <= v;
		do @(posedge clk); while (busy);
		pending_results.push_back(stack_apply(code, v));
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Hold off the sender until every outstanding result has come back
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic test_empty_stack();
		issue(OP_POP, 32'h0000_0005);
		issue(OP_SEARCH, 32'h0000_0000);
		issue(OP_REMOVE, 32'hFFFF_FFFF);
		issue(OP_UNUSED_6, 32'h1234_5678);
		issue(OP_UNUSED_7, 32'h8000_0000);
		wait_drained();
	endtask

	// Fill to the top with extreme and duplicate values, push once more, then count
	task automatic test_fill_to_full();
		logic [31:0] fill_vals [STACK_DEPTH];
		fill_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
			32'h0000_0001, 32'hFFFF_FFFD, 32'hFFFF_FFFC, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h0000_0007, 32'h0000_0007, 32'h0000_0064,
			32'hFFFF_FF9C, 32'h1234_5678, 32'hFFFF_FFFE, 32'h0000_0002};
		foreach (fill_vals[i])
			issue(OP_PUSH, fill_vals[i]);
		issue(OP_PUSH, 32'h0000_002A);
		issue(OP_COUNT, 32'h0000_0000);
	endtask

	// Duplicate match from the top, long shift from the bottom, pop, clear
	task automatic test_search_remove();
		issue(OP_SEARCH, 32'h0000_0007);
		issue(OP_REMOVE, 32'h0000_0007);
		issue(OP_REMOVE, 32'h8000_0000);
		issue(OP_POP, 32'h0000_0000);
		issue(OP_CLEAR, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	// Mostly values from a small pool so search and remove find matches
	function automatic logic [31:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return value_pool[$urandom_range(0, 7)];
		if (r == 7)
			return $urandom;
		if (r == 8) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'hFFFF_FFFF;
				default: return 32'h0000_0000;
			endcase
		end
		return 32'($urandom_range(0, 15)) - 32'd8;
	endfunction

	// Alternate between filling and draining so both ends of the stack are hit
	function automatic logic [2:0] pick_op(bit grow);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < (grow ? 45 : 15))
			return OP_PUSH;
		if (r < (grow ? 55 : 45))
			return OP_POP;
		if (r < (grow ? 70 : 60))
			return OP_SEARCH;
		if (r < 82)
			return OP_REMOVE;
		if (r < 93)
			return OP_COUNT;
		if (r < 95)
			return OP_CLEAR;
		if (r < 97)
			return OP_UNUSED_6;
		return OP_UNUSED_7;
	endfunction

	task automatic test_random_traffic();
		for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
			foreach (value_pool[i])
				value_pool[i] = ($urandom_range(0, 1) == 0) ? $urandom : 32'($urandom_range(0, 20));
			for (int unsigned n = 0; n < PHASE_ITEMS; n++)
				issue(pick_op(((n / 30) % 2) == 0), pick_value());
			wait_drained();
		end
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] want,
		input logic [31:0] got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		fail_count++;
	endtask

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		stack_result_t due;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result transfer with none outstanding", $time);
				fail_count++;
			end else begin
				due = pending_results.pop_front();
				if (status !== due.status)
					report_mismatch("status", 32'(due.status), 32'(status));
				if (found !== due.found)
					report_mismatch("found", 32'(due.found), 32'(found));
				if (popped_value !== due.popped)
					report_mismatch("popped_value", due.popped, popped_value);
				if (even_count !== due.evens)
					report_mismatch("even_count", 32'(due.evens), 32'(even_count));
				if (odd_count !== due.odds)
					report_mismatch("odd_count", 32'(due.odds), 32'(odd_count));
				if (fill_level !== due.level)
					report_mismatch("fill_level", 32'(due.level), 32'(fill_level));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_stack();
		test_fill_to_full();
		test_search_remove();
		test_random_traffic();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/svs_pkg.sv
rtl/core/svs_ram.sv
rtl/core/searchable_value_stack.sv
tb/tb.sv
